FILE: hw/rtl/atan2p_pkg.sv
// Shared types and constants for the atan2 polynomial pipeline.
// Holds the Q30 coefficient set, internal widths and the quadrant flag bundle.
// Depends on nothing; every other file of the block refers to it by scoped names.
package atan2p_pkg;

    // Internal fixed-point format is Q30.
    localparam int QF   = 30;
    // Ratio and its square live in [0, 1], so one integer bit above Q30.
    localparam int TW   = QF + 1;
    // Magnitude width taken into a multiplier (|p| < 2^32).
    localparam int MW   = QF + 2;
    // Signed width of polynomial terms and angles (|angle| <= pi).
    localparam int PW   = QF + 4;
    // Full product width of one multiplier.
    localparam int PRW  = MW + TW;
    // Number of multiply-accumulate steps: t^2, five Horner steps, final times t.
    localparam int NMAC = 7;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    localparam logic [63:0] Q30_ONE  = 64'd1 << QF;
    localparam logic [63:0] DEC_ONE  = 64'd1000000000;
    localparam logic [63:0] DEC_HALF = 64'd500000000;

    // Decimal constants scaled by 2^30, rounded to nearest.
    localparam logic [63:0] K11_Q     = (64'd13480470 * Q30_ONE + DEC_HALF) / DEC_ONE;
    localparam logic [63:0] K9_Q      = (64'd57477314 * Q30_ONE + DEC_HALF) / DEC_ONE;
    localparam logic [63:0] K7_Q      = (64'd121239071 * Q30_ONE + DEC_HALF) / DEC_ONE;
    localparam logic [63:0] K5_Q      = (64'd195635925 * Q30_ONE + DEC_HALF) / DEC_ONE;
    localparam logic [63:0] K3_Q      = (64'd332994597 * Q30_ONE + DEC_HALF) / DEC_ONE;
    localparam logic [63:0] K1_Q      = (64'd999995630 * Q30_ONE + DEC_HALF) / DEC_ONE;
    localparam logic [63:0] HALF_PI_Q = (64'd1570796327 * Q30_ONE + DEC_HALF) / DEC_ONE;
    localparam logic [63:0] PI_Q      = (64'd3141592654 * Q30_ONE + DEC_HALF) / DEC_ONE;

    // Starting value of the Horner recurrence.
    localparam logic signed [PW-1:0] P_INIT = PW'(64'd0 - K11_Q);

    // Constant added after each multiply step, in pipeline order.
    localparam logic signed [PW-1:0] MAC_ADD [NMAC] = '{
        PW'(64'd0),
        PW'(K9_Q),
        PW'(64'd0 - K7_Q),
        PW'(K5_Q),
        PW'(64'd0 - K3_Q),
        PW'(K1_Q),
        PW'(64'd0)
    };

    localparam logic signed [PW-1:0] HALF_PI_P = PW'(HALF_PI_Q);
    localparam logic signed [PW-1:0] PI_P      = PW'(PI_Q);

    // Octant and quadrant information that rides along with each request.
    typedef struct packed {
        logic zero;   // both coordinates are zero
        logic swap;   // |y| > |x|, reflect about pi/2
        logic xneg;   // x negative, reflect about pi
        logic yneg;   // y negative, negate
    } flags_t;

endpackage

FILE: hw/rtl/atan2p_div_stage.sv
// One radix-2 restoring division stage of the ratio divider.
// Produces one quotient bit per register stage.
// Depends on atan2p_pkg.
module atan2p_div_stage #(
    parameter int COORD_WIDTH = atan2p_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [COORD_WIDTH-1:0]        in_rem,
    input  logic [COORD_WIDTH-1:0]        in_hi,
    input  logic [atan2p_pkg::TW-1:0]     in_sw,
    input  atan2p_pkg::flags_t            in_flags,
    output logic                          out_valid,
    output logic [COORD_WIDTH-1:0]        out_rem,
    output logic [COORD_WIDTH-1:0]        out_hi,
    output logic [atan2p_pkg::TW-1:0]     out_sw,
    output atan2p_pkg::flags_t            out_flags
);

    logic                          valid_reg;
    logic [COORD_WIDTH-1:0]        rem_reg;
    logic [COORD_WIDTH-1:0]        rem_next;
    logic [COORD_WIDTH-1:0]        hi_reg;
    logic [atan2p_pkg::TW-1:0]     sw_reg;
    logic [atan2p_pkg::TW-1:0]     sw_next;
    atan2p_pkg::flags_t            flags_reg;

    logic [COORD_WIDTH:0]          trial;
    logic [COORD_WIDTH:0]          diff;
    logic                          take;

    // The shift word holds the dividend bits still to come in its upper part
    // and the quotient bits produced so far in its lower part.
    always_comb begin
        trial    = {in_rem, in_sw[atan2p_pkg::TW-1]};
        diff     = trial - {1'b0, in_hi};
        take     = (trial >= {1'b0, in_hi});
        rem_next = take ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
        sw_next  = {in_sw[atan2p_pkg::TW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg   <= rem_next;
            hi_reg    <= in_hi;
            sw_reg    <= sw_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_hi    = hi_reg;
    assign out_sw    = sw_reg;
    assign out_flags = flags_reg;

endmodule

FILE: hw/rtl/atan2p_mac.sv
// One multiply, round and add step of the polynomial, in two register stages.
// Stage one forms the magnitude product; stage two rounds, restores the sign and adds.
// Depends on atan2p_pkg.
module atan2p_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [atan2p_pkg::PW-1:0]     in_p,
    input  logic [atan2p_pkg::TW-1:0]            in_b,
    input  logic [atan2p_pkg::TW-1:0]            in_t,
    input  atan2p_pkg::flags_t                   in_flags,
    input  logic signed [atan2p_pkg::PW-1:0]     addend,
    output logic                                 out_valid,
    output logic signed [atan2p_pkg::PW-1:0]     out_p,
    output logic [atan2p_pkg::TW-1:0]            out_b,
    output logic [atan2p_pkg::TW-1:0]            out_t,
    output atan2p_pkg::flags_t                   out_flags
);

    localparam int PW  = atan2p_pkg::PW;
    localparam int TW  = atan2p_pkg::TW;
    localparam int MW  = atan2p_pkg::MW;
    localparam int PRW = atan2p_pkg::PRW;
    localparam int QF  = atan2p_pkg::QF;
    localparam logic [PRW:0] RND_HALF = (PRW+1)'(1) << (QF - 1);

    // Stage one.
    logic               v1_reg;
    logic [PRW-1:0]     prod_reg;
    logic [PRW-1:0]     prod_next;
    logic               neg_reg;
    logic [TW-1:0]      b1_reg;
    logic [TW-1:0]      t1_reg;
    atan2p_pkg::flags_t f1_reg;
    logic [PW-1:0]      abs_p;

    // Stage two.
    logic               v2_reg;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] p_next;
    logic [TW-1:0]      b2_reg;
    logic [TW-1:0]      t2_reg;
    atan2p_pkg::flags_t f2_reg;
    logic [PRW:0]       rsum;
    logic [PW-1:0]      rmag;

    always_comb begin
        abs_p     = in_p[PW-1] ? (PW'(0) - in_p) : in_p;
        prod_next = PRW'(abs_p[MW-1:0]) * PRW'(in_b);
    end

    // Round to nearest with ties away from zero, then put the sign back.
    always_comb begin
        rsum   = {1'b0, prod_reg} + RND_HALF;
        rmag   = PW'(rsum[PRW:QF]);
        p_next = (neg_reg ? (PW'(0) - rmag) : rmag) + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            neg_reg  <= in_p[PW-1];
            b1_reg   <= in_b;
            t1_reg   <= in_t;
            f1_reg   <= in_flags;
            p_reg    <= p_next;
            b2_reg   <= b1_reg;
            t2_reg   <= t1_reg;
            f2_reg   <= f1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_p     = p_reg;
    assign out_b     = b2_reg;
    assign out_t     = t2_reg;
    assign out_flags = f2_reg;

endmodule

FILE: hw/rtl/atan2p_horner.sv
// Degree-11 odd polynomial for the first-octant arctangent, as a chain of MAC steps.
// Squares the ratio, runs five Horner steps in t^2, then multiplies by t.
// Depends on atan2p_pkg and atan2p_mac.
module atan2p_horner (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [atan2p_pkg::TW-1:0]            in_t,
    input  atan2p_pkg::flags_t                   in_flags,
    output logic                                 out_valid,
    output logic signed [atan2p_pkg::PW-1:0]     out_a,
    output atan2p_pkg::flags_t                   out_flags
);

    localparam int PW   = atan2p_pkg::PW;
    localparam int TW   = atan2p_pkg::TW;
    localparam int NMAC = atan2p_pkg::NMAC;

    logic                 mv [NMAC+1];
    logic signed [PW-1:0] mp [NMAC+1];
    logic [TW-1:0]        mb [NMAC+1];
    logic [TW-1:0]        mt [NMAC+1];
    atan2p_pkg::flags_t   mf [NMAC+1];

    assign mv[0] = in_valid;
    assign mp[0] = PW'(in_t);
    assign mb[0] = in_t;
    assign mt[0] = in_t;
    assign mf[0] = in_flags;

    for (genvar g = 0; g < NMAC; g++) begin : g_mac
        logic signed [PW-1:0] p_sel;
        logic [TW-1:0]        b_sel;

        if (g == 1) begin : g_init
            // The first step squared t; that square becomes the multiplier.
            assign p_sel = atan2p_pkg::P_INIT;
            assign b_sel = mp[g][TW-1:0];
        end else if (g == NMAC - 1) begin : g_final
            assign p_sel = mp[g];
            assign b_sel = mt[g];
        end else begin : g_mid
            assign p_sel = mp[g];
            assign b_sel = mb[g];
        end

        atan2p_mac u_mac (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (mv[g]),
            .in_p      (p_sel),
            .in_b      (b_sel),
            .in_t      (mt[g]),
            .in_flags  (mf[g]),
            .addend    (atan2p_pkg::MAC_ADD[g]),
            .out_valid (mv[g+1]),
            .out_p     (mp[g+1]),
            .out_b     (mb[g+1]),
            .out_t     (mt[g+1]),
            .out_flags (mf[g+1])
        );
    end

    assign out_valid = mv[NMAC];
    assign out_a     = mp[NMAC];
    assign out_flags = mf[NMAC];

endmodule

FILE: hw/rtl/atan2p_fold.sv
// Octant and quadrant reflection of the first-octant angle, then output rounding.
// Three register stages: pi/2 reflection, pi reflection with sign, round to the output grid.
// Depends on atan2p_pkg.
module atan2p_fold #(
    parameter int ANGLE_FRAC_BITS = atan2p_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [atan2p_pkg::PW-1:0]     in_a,
    input  atan2p_pkg::flags_t                   in_flags,
    output logic                                 out_valid,
    output logic [ANGLE_FRAC_BITS+2:0]           out_angle
);

    localparam int PW = atan2p_pkg::PW;
    localparam int OW = ANGLE_FRAC_BITS + 3;
    localparam int SH = atan2p_pkg::QF - ANGLE_FRAC_BITS;
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (SH - 1);

    logic                 va_reg;
    logic signed [PW-1:0] a1_reg;
    logic signed [PW-1:0] a1_next;
    atan2p_pkg::flags_t   fa_reg;

    logic                 vb_reg;
    logic signed [PW-1:0] a2_reg;
    logic signed [PW-1:0] a2_next;
    logic signed [PW-1:0] offset;
    logic                 zb_reg;

    logic                 vc_reg;
    logic [OW-1:0]        angle_reg;
    logic [OW-1:0]        angle_next;
    logic [PW-1:0]        mag;
    logic [PW-1:0]        rnd_mag;

    assign a1_next = in_flags.swap ? (atan2p_pkg::HALF_PI_P - in_a) : in_a;

    // pi - a for negative x, then negation for negative y, folded into one add.
    always_comb begin
        if (fa_reg.xneg) begin
            offset = fa_reg.yneg ? (PW'(0) - atan2p_pkg::PI_P) : atan2p_pkg::PI_P;
        end else begin
            offset = '0;
        end
        a2_next = ((fa_reg.xneg ^ fa_reg.yneg) ? (PW'(0) - a1_reg) : a1_reg) + offset;
    end

    always_comb begin
        mag     = a2_reg[PW-1] ? (PW'(0) - a2_reg) : a2_reg;
        rnd_mag = (mag + HALF_LSB) >> SH;
        if (zb_reg) begin
            angle_next = '0;
        end else if (a2_reg[PW-1]) begin
            angle_next = OW'(PW'(0) - rnd_mag);
        end else begin
            angle_next = OW'(rnd_mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg    <= a1_next;
            fa_reg    <= in_flags;
            a2_reg    <= a2_next;
            zb_reg    <= fa_reg.zero;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_angle = angle_reg;

endmodule

FILE: hw/rtl/atan2_polynomial.sv
// atan2_polynomial: four-quadrant arctangent, fully pipelined, one request per clock
// while the skid register is empty. An accepted request passes, in order, through
// one front-end stage, 31 divider stages (one quotient bit each), 14 polynomial stages
// (seven multipliers, two stages each), three reflection/rounding stages, the output register.
// Throughput is one request per cycle while the skid register is empty.
// aresetn is synchronous and active low; it empties the pipeline and the output buffer.
module atan2_polynomial #(
    parameter int COORD_WIDTH     = atan2p_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = atan2p_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Input requests. s_tdata: coord_y (lowest bits), coord_x, zero padding.
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    // Results. m_tdata: angle (lowest bits), zero padding.
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]    m_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int TW   = atan2p_pkg::TW;
    localparam int QF   = atan2p_pkg::QF;
    localparam int PW   = atan2p_pkg::PW;
    localparam int OW   = ANGLE_FRAC_BITS + 3;
    localparam int OTDW = ((OW + 7) / 8) * 8;
    // Dividend width: smaller magnitude shifted up by QF plus half the divisor.
    localparam int NW   = CW + TW;
    localparam int SH   = QF - ANGLE_FRAC_BITS;

    // The whole pipeline advances together; it only halts while the skid
    // register holds a result, so s_tready comes straight from a flip-flop.
    logic pipe_en;

    // ------------------------------------------------------------------
    // Front end: magnitudes, octant decision and the rounded dividend.
    // ------------------------------------------------------------------
    logic [CW-1:0]      coord_y;
    logic [CW-1:0]      coord_x;
    logic [CW-1:0]      mag_y;
    logic [CW-1:0]      mag_x;
    logic [CW-1:0]      hi;
    logic [CW-1:0]      lo;
    logic [NW-1:0]      dividend;
    atan2p_pkg::flags_t fe_flags_next;

    logic               fe_valid_reg;
    logic [CW-1:0]      fe_rem_reg;
    logic [CW-1:0]      fe_hi_reg;
    logic [TW-1:0]      fe_sw_reg;
    atan2p_pkg::flags_t fe_flags_reg;

    assign coord_y = s_tdata[CW-1:0];
    assign coord_x = s_tdata[2*CW-1:CW];

    // The most negative code has magnitude 2^(CW-1), which still fits CW
    // unsigned bits, so plain two's complement negation is exact.
    always_comb begin
        mag_y = coord_y[CW-1] ? (CW'(0) - coord_y) : coord_y;
        mag_x = coord_x[CW-1] ? (CW'(0) - coord_x) : coord_x;
        fe_flags_next.swap = (mag_y > mag_x);
        fe_flags_next.xneg = coord_x[CW-1];
        fe_flags_next.yneg = coord_y[CW-1];
        hi = fe_flags_next.swap ? mag_y : mag_x;
        lo = fe_flags_next.swap ? mag_x : mag_y;
        fe_flags_next.zero = (hi == '0);
        // Adding half the divisor turns the truncating divide into round to nearest.
        dividend = NW'({lo, {QF{1'b0}}}) + NW'(hi >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fe_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            fe_valid_reg <= s_tvalid;
        end
    end

    // The quotient is at most 2^QF, so the top CW dividend bits are already
    // below the divisor and seed the partial remainder.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            fe_rem_reg   <= dividend[NW-1:TW];
            fe_hi_reg    <= hi;
            fe_sw_reg    <= dividend[TW-1:0];
            fe_flags_reg <= fe_flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Ratio divider: TW restoring stages, one quotient bit per stage.
    // ------------------------------------------------------------------
    logic               dv_valid [TW+1];
    logic [CW-1:0]      dv_rem   [TW+1];
    logic [CW-1:0]      dv_hi    [TW+1];
    logic [TW-1:0]      dv_sw    [TW+1];
    atan2p_pkg::flags_t dv_flags [TW+1];

    assign dv_valid[0] = fe_valid_reg;
    assign dv_rem[0]   = fe_rem_reg;
    assign dv_hi[0]    = fe_hi_reg;
    assign dv_sw[0]    = fe_sw_reg;
    assign dv_flags[0] = fe_flags_reg;

    for (genvar d = 0; d < TW; d++) begin : g_div
        atan2p_div_stage #(
            .COORD_WIDTH (CW)
        ) u_div_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (dv_valid[d]),
            .in_rem    (dv_rem[d]),
            .in_hi     (dv_hi[d]),
            .in_sw     (dv_sw[d]),
            .in_flags  (dv_flags[d]),
            .out_valid (dv_valid[d+1]),
            .out_rem   (dv_rem[d+1]),
            .out_hi    (dv_hi[d+1]),
            .out_sw    (dv_sw[d+1]),
            .out_flags (dv_flags[d+1])
        );
    end

    // ------------------------------------------------------------------
    // First-octant arctangent of the ratio t = dv_sw[TW].
    // ------------------------------------------------------------------
    logic                 hn_valid;
    logic signed [PW-1:0] hn_a;
    atan2p_pkg::flags_t   hn_flags;

    atan2p_horner u_horner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (dv_valid[TW]),
        .in_t      (dv_sw[TW]),
        .in_flags  (dv_flags[TW]),
        .out_valid (hn_valid),
        .out_a     (hn_a),
        .out_flags (hn_flags)
    );

    // ------------------------------------------------------------------
    // Reflection into the right octant and quadrant, output rounding.
    // The origin leaves this block as angle zero.
    // ------------------------------------------------------------------
    logic          fold_valid;
    logic [OW-1:0] fold_angle;

    atan2p_fold #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (hn_valid),
        .in_a      (hn_a),
        .in_flags  (hn_flags),
        .out_valid (fold_valid),
        .out_angle (fold_angle)
    );

    // ------------------------------------------------------------------
    // Output register with a one-entry skid register behind it. When the
    // consumer stalls, the result leaving the pipeline parks in the skid
    // register, and only then does the pipeline stop taking requests.
    // ------------------------------------------------------------------
    logic          m_valid_reg;
    logic [OW-1:0] m_angle_reg;
    logic          skid_valid_reg;
    logic [OW-1:0] skid_angle_reg;
    logic          out_load;

    assign pipe_en  = ~skid_valid_reg;
    assign out_load = ~m_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= skid_valid_reg | (pipe_en & fold_valid);
            end
            if (skid_valid_reg) begin
                skid_valid_reg <= ~out_load;
            end else begin
                skid_valid_reg <= fold_valid & ~out_load;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_angle_reg <= skid_valid_reg ? skid_angle_reg : fold_angle;
        end
        if (pipe_en & ~out_load) begin
            skid_angle_reg <= fold_angle;
        end
    end

    assign s_tready = pipe_en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OTDW'(m_angle_reg);

`ifndef NO_ASSERTIONS
    localparam logic signed [OW-1:0] ANGLE_MAX =
        OW'((atan2p_pkg::PI_Q + (64'd1 << (SH - 1))) >> SH);

    // A parked result always has an older result in front of it.
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full while output register empty");

    // Once the consumer takes a result, the skid register drains at once.
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg)
        else $error("skid register did not drain");

    // A halted pipeline holds the result that is about to leave it.
    a_pipe_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(fold_valid) && $stable(fold_angle)))
        else $error("pipeline moved while halted");

    // Every result lies within minus pi to pi.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (($signed(m_angle_reg) <= ANGLE_MAX) &&
                         ($signed(m_angle_reg) >= -ANGLE_MAX)))
        else $error("angle outside minus pi to pi");
`endif

endmodule

FILE: dv/atan2_polynomial_checker.sv
`timescale 1ns / 1ps
// Result checker for atan2_polynomial: predicts the angle of every accepted
// coordinate request and compares it with the result channel in order.
// Stands alone; it needs only the stream signals of the block.
module atan2_polynomial_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // coord_y [15:0], coord_x [31:16]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // angle [15:0]
    output int          mismatches,
    output int          outstanding
);

    localparam int FRAC  = 30;
    localparam int SHIFT = FRAC - 13;

    // Decimal constant given in units of 1e-9, scaled to Q30 with rounding.
    function automatic longint q30_of(longint unsigned nano);
        return longint'(((nano << FRAC) + 64'd500000000) / 64'd1000000000);
    endfunction

    localparam longint C11     = q30_of(64'd13480470);
    localparam longint C9      = q30_of(64'd57477314);
    localparam longint C7      = q30_of(64'd121239071);
    localparam longint C5      = q30_of(64'd195635925);
    localparam longint C3      = q30_of(64'd332994597);
    localparam longint C1      = q30_of(64'd999995630);
    localparam longint HALF_PI = q30_of(64'd1570796327);
    localparam longint PI      = q30_of(64'd3141592654);

    // Signed Q30 times unsigned Q30, rounded to nearest with ties away from zero.
    function automatic longint q30_mul(longint a, longint unsigned b);
        logic neg;
        longint unsigned m, r;
        neg = a < 0;
        m = neg ? longint'(-a) : a;
        r = (m * b + (64'd1 << (FRAC - 1))) >> FRAC;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [15:0] predict_angle(logic [15:0] y_raw, logic [15:0] x_raw);
        longint unsigned ay, ax, hi, lo, t, t2, mag;
        longint p, a;
        logic aneg;
        ay = y_raw[15] ? 64'd65536 - y_raw : 64'(y_raw);
        ax = x_raw[15] ? 64'd65536 - x_raw : 64'(x_raw);
        hi = (ay > ax) ? ay : ax;
        lo = (ay > ax) ? ax : ay;
        if (hi == 0)
            return 16'd0;
        t  = ((lo << FRAC) + (hi >> 1)) / hi;
        t2 = (t * t + (64'd1 << (FRAC - 1))) >> FRAC;
        p = -C11;
        p = q30_mul(p, t2) + C9;
        p = q30_mul(p, t2) - C7;
        p = q30_mul(p, t2) + C5;
        p = q30_mul(p, t2) - C3;
        p = q30_mul(p, t2) + C1;
        a = q30_mul(p, t);
        if (ay > ax)
            a = HALF_PI - a;
        if (x_raw[15])
            a = PI - a;
        if (y_raw[15])
            a = -a;
        aneg = a < 0;
        mag = aneg ? longint'(-a) : a;
        mag = (mag + (64'd1 << (SHIFT - 1))) >> SHIFT;
        return aneg ? 16'(64'd0 - mag) : 16'(mag);
    endfunction

    logic [15:0] expected_angles [$];
    logic [15:0] want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_angles.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_angles.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected angle %0d", $realtime, $signed(m_tdata));
                end else begin
                    want = expected_angles.pop_front();
                    if (m_tdata !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: angle expected %0d got %0d", $realtime,
                                     $signed(want), $signed(m_tdata));
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_angles.push_back(predict_angle(s_tdata[15:0], s_tdata[31:16]));
        end
        outstanding = expected_angles.size();
    end

endmodule

FILE: dv/atan2_polynomial_test.sv
`timescale 1ns / 1ps
// Top of the atan2_polynomial testbench: clock, reset, coordinate stimulus and
// random backpressure. Depends on the block and on atan2_polynomial_checker.
module atan2_polynomial_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // coord_y [15:0], coord_x [31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // angle [15:0]

    int mismatches;
    int outstanding;

    // When set, neither side inserts idle cycles; used for the final stretch
    // so the pipeline also runs at full rate.
    bit steady = 1'b0;

    always #1 aclk = ~aclk;

    atan2_polynomial dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    atan2_polynomial_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offers one coordinate request and holds it until the block takes it.
    // Inputs change only at the falling edge; s_tready is looked at on the
    // rising edge, where the handshake happens. Before the request there may
    // be a burst of idle cycles, which lowers s_tvalid for that burst only.
    task automatic send_request(input int y, input int x);
        int gap;
        if (!steady && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(x), 16'(y)};
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops offering requests until every predicted angle has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    // Result side: m_tready drops in random bursts of idle cycles, except in the
    // steady stretch at the end where results are always taken.
    int stall_left = 0;
    always @(negedge aclk) begin
        if (steady) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int n;
        int kind;
        int y, x;
        int pick;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests: the origin, all four axes, the corners of the
        // coordinate range including the most negative value, points just off
        // the negative x axis on both sides, and equal magnitudes, where no
        // reflection about pi/2 takes place.
        send_request(0, 0);
        send_request(100, 0);
        send_request(-100, 0);
        send_request(0, -100);
        send_request(0, 100);
        send_request(32767, 0);
        send_request(-32768, 0);
        send_request(0, -32768);
        send_request(0, 32767);
        send_request(-32768, -32768);
        send_request(32767, 32767);
        send_request(32767, -32768);
        send_request(-32768, 32767);
        send_request(1, -32768);
        send_request(-1, -32768);
        send_request(1, 32767);
        send_request(32767, 1);
        send_request(-32768, -1);
        send_request(5, -5);
        send_request(-5, 5);
        send_request(1, 1);
        send_request(-1, -1);

        // Let the pipeline empty completely once before the random part.
        drain_results();

        for (n = 0; n < 950; n++) begin
            steady = (n >= 800);
            if (n == 400)
                drain_results();
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // Anywhere in the plane; every bit of both fields toggles here.
                y = int'($urandom_range(0, 65535)) - 32768;
                x = int'($urandom_range(0, 65535)) - 32768;
            end else if (kind < 60) begin
                // Tiny vectors around the origin, zeros and exact ratios included.
                y = int'($urandom_range(0, 32)) - 16;
                x = int'($urandom_range(0, 32)) - 16;
            end else if (kind < 75) begin
                // Near the diagonals, where the octant swap decision flips.
                x = int'($urandom_range(0, 65535)) - 32768;
                y = ($urandom_range(0, 1) ? x : -x) + int'($urandom_range(0, 6)) - 3;
            end else if (kind < 85) begin
                // One coordinate zero, plus or minus one, or at an extreme value.
                pick = $urandom_range(0, 4);
                case (pick)
                    0: y = -32768;
                    1: y = 32767;
                    2: y = 0;
                    3: y = -1;
                    default: y = 1;
                endcase
                x = int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 1)) begin
                    pick = y;
                    y = x;
                    x = pick;
                end
            end else begin
                // Very small ratio: one coordinate tiny, the other large.
                y = int'($urandom_range(0, 6)) - 3;
                x = int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 1)) begin
                    pick = y;
                    y = x;
                    x = pick;
                end
            end
            send_request(y, x);
        end

        // Wait for every angle, then a pipeline's worth of cycles more so that
        // a stray extra result would still be caught.
        drain_results();
        repeat (60) @(negedge aclk);

        if (mismatches == 0)
            $display("atan2_polynomial_test: clean");
        else
            $display("atan2_polynomial_test: errors");
        $finish;
    end

    // Safety net against a hung handshake; far beyond the slowest correct run.
    initial begin
        #500000;
        $display("atan2_polynomial_test: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/atan2p_pkg.sv
hw/rtl/atan2p_div_stage.sv
hw/rtl/atan2p_mac.sv
hw/rtl/atan2p_horner.sv
hw/rtl/atan2p_fold.sv
hw/rtl/atan2_polynomial.sv
dv/atan2_polynomial_checker.sv
dv/atan2_polynomial_test.sv
